FILE: src/jsac_pkg.sv
// Shared types, constants and helper functions for the joystick servo arm control block.
// Depends on nothing; every other file imports it.
package jsac_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ANGLE_W     = 8;
    localparam int LEVEL_W     = 13;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int NUM_W       = ANGLE_W + SAMPLE_BITS;
    localparam int STEP_W      = $clog2(ANGLE_W);
    localparam int SUM_W       = 12;
    localparam int SCALE_W     = 25;
    localparam int LPROD_W     = 31;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    localparam logic [ANGLE_W-1:0]     ANGLE_CAP  = 8'd180;
    localparam logic [ANGLE_W-1:0]     POS_RESET  = 8'd90;
    localparam logic [LEVEL_W-1:0]     LEVEL_BASE = 13'd2500;
    // 2500/180 = 125/9; 1/9 as 58255 / 2^19, folded with 125
    localparam logic [LPROD_W-1:0]     LEVEL_MUL  = 31'd7281875;
    localparam int                     LEVEL_SHR  = 19;
    // 1/10 as 6554 / 2^16
    localparam logic [SCALE_W-1:0]     TENTH_MUL  = 25'd6554;
    localparam int                     TENTH_SHR  = 16;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_BAND = 3'd2,
        REG_ARM_MIN     = 3'd3,
        REG_ARM_MAX     = 3'd4,
        REG_GRIP_OPEN   = 3'd5,
        REG_GRIP_SHUT   = 3'd6,
        REG_DEBOUNCE    = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_SMOOTH,
        LN_SCALE
    } t_lane_state;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_RUN,
        TP_LEVEL
    } t_top_state;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] joy_x;
        logic [SAMPLE_BITS-1:0] joy_y;
        logic                   button;
        logic [TIME_W-1:0]      now_ms;
    } t_joy_word;

    typedef struct packed {
        logic [ANGLE_W-1:0] shoulder_angle;
        logic [ANGLE_W-1:0] elbow_angle;
        logic [ANGLE_W-1:0] grip_angle;
        logic               grip_is_closed;
        logic [LEVEL_W-1:0] shoulder_level;
        logic [LEVEL_W-1:0] elbow_level;
        logic [LEVEL_W-1:0] grip_level;
    } t_servo_word;

    typedef struct packed {
        logic [ANGLE_W-1:0]     lo;
        logic [ANGLE_W-1:0]     hi;
        logic [ANGLE_W-1:0]     mid;
        logic [SAMPLE_BITS-1:0] center_band;
    } t_lane_cfg;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] pos;
    } t_lane_stat;

    function automatic logic [ANGLE_W-1:0] jsac_cap(input logic [ANGLE_W-1:0] a);
        return (a > ANGLE_CAP) ? ANGLE_CAP : a;
    endfunction

    function automatic logic [LEVEL_W-1:0] jsac_level(input logic [ANGLE_W-1:0] a);
        logic [LPROD_W-1:0] prod;
        prod = LPROD_W'(jsac_cap(a)) * LEVEL_MUL;
        return LEVEL_BASE + LEVEL_W'(prod >> LEVEL_SHR);
    endfunction

endpackage

FILE: src/jsac_in_if.sv
// Joystick sample channel: valid/ready handshake carrying one t_joy_word.
// Depends on jsac_pkg.
interface jsac_in_if import jsac_pkg::*; ();
    logic      valid;
    logic      ready;
    t_joy_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/jsac_out_if.sv
// Servo result channel: valid/ready handshake carrying one t_servo_word.
// Depends on jsac_pkg.
interface jsac_out_if import jsac_pkg::*; ();
    logic        valid;
    logic        ready;
    t_servo_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/jsac_axis_lane.sv
// One axis lane: dead zone test, piecewise-linear map via shift-subtract divider, smoothing.
// Holds the joint position. Depends on jsac_pkg.
module jsac_axis_lane import jsac_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_center,
    input  t_lane_cfg              i_cfg,
    output t_lane_stat             o_stat
);

    t_lane_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_v;
    logic [NUM_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [ANGLE_W-1:0]     r_base;
    logic [ANGLE_W-1:0]     r_quo;
    logic [STEP_W-1:0]      r_step;
    logic [SUM_W-1:0]       r_sum;
    logic [ANGLE_W-1:0]     r_pos;

    logic [SAMPLE_BITS-1:0] w_dist;
    logic                   w_below;
    logic                   w_centered;
    logic [ANGLE_W-1:0]     w_mul_a;
    logic [SAMPLE_BITS-1:0] w_mul_b;
    logic [SAMPLE_BITS-1:0] w_den;
    logic [ANGLE_W-1:0]     w_base;
    logic [NUM_W-1:0]       w_trial;
    logic [ANGLE_W:0]       w_target;
    logic [SCALE_W-1:0]     w_scaled;

    // dead zone and segment choice
    always_comb begin
        w_below    = r_v < i_center;
        w_dist     = w_below ? (i_center - r_v) : (r_v - i_center);
        w_centered = w_dist < i_cfg.center_band;
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_den      = SAMPLE_BITS'(1);
        w_base     = i_cfg.mid;
        if (!w_centered) begin
            if (w_below) begin
                w_mul_a = i_cfg.mid - i_cfg.lo;
                w_mul_b = r_v;
                w_den   = i_center;
                w_base  = i_cfg.lo;
            end else if (i_center != FULL_SCALE) begin
                w_mul_a = i_cfg.hi - i_cfg.mid;
                w_mul_b = r_v - i_center;
                w_den   = FULL_SCALE - i_center;
            end
        end
    end

    assign w_trial  = NUM_W'(r_den) << r_step;
    assign w_target = (ANGLE_W+1)'(r_base) + (ANGLE_W+1)'(r_quo);
    assign w_scaled = SCALE_W'(r_sum) * TENTH_MUL;

    always_comb begin
        n_state = r_state;
        case (r_state)
            LN_IDLE:   if (i_start) n_state = LN_MUL;
            LN_MUL:    n_state = LN_DIV;
            LN_DIV:    if (r_step == '0) n_state = LN_SMOOTH;
            LN_SMOOTH: n_state = LN_SCALE;
            LN_SCALE:  n_state = LN_IDLE;
            default:   n_state = LN_IDLE;
        endcase
    end

    always_comb begin
        o_stat.done = (r_state == LN_SCALE);
        o_stat.pos  = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_pos   <= POS_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == LN_SCALE) begin
                r_pos <= w_scaled[TENTH_SHR +: ANGLE_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            LN_IDLE: begin
                if (i_start) r_v <= i_sample;
            end
            LN_MUL: begin
                r_rem  <= NUM_W'(w_mul_a) * NUM_W'(w_mul_b);
                r_den  <= w_den;
                r_base <= w_base;
                r_quo  <= '0;
                r_step <= STEP_W'(ANGLE_W - 1);
            end
            LN_DIV: begin
                if (r_rem >= w_trial) begin
                    r_rem         <= r_rem - w_trial;
                    r_quo[r_step] <= 1'b1;
                end
                r_step <= r_step - STEP_W'(1);
            end
            LN_SMOOTH: begin
                r_sum <= SUM_W'(r_pos) * SUM_W'(7) + SUM_W'(w_target) * SUM_W'(3);
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/joystick_servo_arm_control.sv
// Joystick servo arm control top: config registers, two axis lanes, gripper toggle, level merge.
// Each accepted word, taken only when no earlier word is in flight, runs through these steps:
// accept, multiply, 8-step divide, smooth and scale in each lane, then the level stage.
// A new word is taken while the previous output word still waits in the output register.
// Synchronous active-low reset restores all config registers, positions 90/90, gripper open.
// Depends on jsac_pkg, jsac_in_if, jsac_out_if and jsac_axis_lane.
module joystick_servo_arm_control import jsac_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    jsac_in_if.sink                i_joy,
    jsac_out_if.source             o_servo,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [DEB_W-1:0]       i_cfg_data
);

    t_top_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_center_x, r_center_y, r_center_band;
    logic [ANGLE_W-1:0]     r_arm_min, r_arm_max, r_grip_open, r_grip_shut;
    logic [DEB_W-1:0]       r_debounce;

    logic                   r_closed;
    logic [ANGLE_W-1:0]     r_grip;
    logic                   r_prev_btn;
    logic [TIME_W-1:0]      r_last;

    logic                   r_out_valid;
    t_servo_word            r_out;

    logic                   w_acc;
    logic                   w_start;
    logic                   w_out_free;
    logic                   w_load_out;
    logic                   w_press;
    logic [TIME_W-1:0]      w_elapsed;
    logic [ANGLE_W-1:0]     w_lo, w_hi, w_hi_raw;
    logic [ANGLE_W:0]       w_mid_sum;
    t_lane_cfg              w_lane_cfg;
    t_lane_stat             w_x_stat, w_y_stat;
    t_reg_idx               w_idx;

    assign w_idx = t_reg_idx'(i_cfg_idx);

    always_comb begin
        w_lo      = jsac_cap(r_arm_min);
        w_hi_raw  = jsac_cap(r_arm_max);
        w_hi      = (w_hi_raw < w_lo) ? w_lo : w_hi_raw;
        w_mid_sum = (ANGLE_W+1)'(w_lo) + (ANGLE_W+1)'(w_hi);
        w_lane_cfg.lo          = w_lo;
        w_lane_cfg.hi          = w_hi;
        w_lane_cfg.mid         = w_mid_sum[ANGLE_W:1];
        w_lane_cfg.center_band = r_center_band;
    end

    jsac_axis_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_sample (i_joy.data.joy_x),
        .i_center (r_center_x),
        .i_cfg    (w_lane_cfg),
        .o_stat   (w_x_stat)
    );

    jsac_axis_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_sample (i_joy.data.joy_y),
        .i_center (r_center_y),
        .i_cfg    (w_lane_cfg),
        .o_stat   (w_y_stat)
    );

    assign w_acc      = i_joy.valid && i_joy.ready;
    assign w_out_free = !r_out_valid || o_servo.ready;
    assign w_elapsed  = i_joy.data.now_ms - r_last;
    assign w_press    = i_joy.data.button && !r_prev_btn
                        && (w_elapsed > TIME_W'(r_debounce));

    always_comb begin
        n_state = r_state;
        case (r_state)
            TP_IDLE:  if (w_acc) n_state = TP_RUN;
            TP_RUN:   if (w_x_stat.done) n_state = TP_LEVEL;
            TP_LEVEL: if (w_out_free) n_state = TP_IDLE;
            default:  n_state = TP_IDLE;
        endcase
    end

    always_comb begin
        i_joy.ready = (r_state == TP_IDLE);
        w_start     = w_acc;
        w_load_out  = (r_state == TP_LEVEL) && w_out_free;
    end

    assign o_servo.valid = r_out_valid;
    assign o_servo.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= TP_IDLE;
            r_center_x    <= SAMPLE_BITS'(2048);
            r_center_y    <= SAMPLE_BITS'(2048);
            r_center_band <= SAMPLE_BITS'(200);
            r_arm_min     <= 8'd10;
            r_arm_max     <= 8'd170;
            r_grip_open   <= 8'd0;
            r_grip_shut   <= 8'd90;
            r_debounce    <= 16'd100;
            r_closed      <= 1'b0;
            r_grip        <= '0;
            r_prev_btn    <= 1'b0;
            r_last        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (w_idx)
                    REG_CENTER_X:    r_center_x    <= i_cfg_data[SAMPLE_BITS-1:0];
                    REG_CENTER_Y:    r_center_y    <= i_cfg_data[SAMPLE_BITS-1:0];
                    REG_CENTER_BAND: r_center_band <= i_cfg_data[SAMPLE_BITS-1:0];
                    REG_ARM_MIN:     r_arm_min     <= i_cfg_data[ANGLE_W-1:0];
                    REG_ARM_MAX:     r_arm_max     <= i_cfg_data[ANGLE_W-1:0];
                    REG_GRIP_OPEN:   r_grip_open   <= i_cfg_data[ANGLE_W-1:0];
                    REG_GRIP_SHUT:   r_grip_shut   <= i_cfg_data[ANGLE_W-1:0];
                    REG_DEBOUNCE:    r_debounce    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_acc) begin
                r_prev_btn <= i_joy.data.button;
                if (w_press) begin
                    r_closed <= !r_closed;
                    r_grip   <= jsac_cap(r_closed ? r_grip_open : r_grip_shut);
                    r_last   <= i_joy.data.now_ms;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_servo.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.shoulder_angle <= w_x_stat.pos;
            r_out.elbow_angle    <= w_y_stat.pos;
            r_out.grip_angle     <= r_grip;
            r_out.grip_is_closed <= r_closed;
            r_out.shoulder_level <= jsac_level(w_x_stat.pos);
            r_out.elbow_level    <= jsac_level(w_y_stat.pos);
            r_out.grip_level     <= jsac_level(r_grip);
        end
    end

`ifndef NO_ASSERTIONS
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_stat.done == w_y_stat.done)
        else $error("axis lanes out of step");

    a_grip_toggle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_closed != $past(r_closed)) |-> $past(w_acc))
        else $error("gripper toggled without an accepted word");

    a_grip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grip <= ANGLE_CAP)
        else $error("gripper angle above cap");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_x_stat.pos <= ANGLE_CAP) && (w_y_stat.pos <= ANGLE_CAP))
        else $error("joint position above cap");

    a_load_after_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_x_stat.done |=> (r_state == TP_LEVEL))
        else $error("merge stage missed lane completion");
`endif

endmodule
